// ===== rtl/gfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gfa_pkg;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // AES field: x^8 + x^4 + x^3 + x + 1
  localparam logic [7:0] GF_REDUCE = 8'h1b;
  localparam logic [7:0] GF_ONE    = 8'h01;
  localparam logic [8:0] GF_POLY   = 9'h11b;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_MUL   = 2'd1,
    OP_INV   = 2'd2,
    OP_XTIME = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] a;
    logic [7:0] b;
  } item_t;

  // Multiply by x, fold the carried-out bit back with the reduction constant
  function automatic logic [7:0] gf_xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
  endfunction

  // Shift-and-add multiply, walking a from its top bit down
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 7; i >= 0; i--) begin
      acc = gf_xtime(acc);
      if (a[i]) begin
        acc = acc ^ b;
      end
    end
    return acc;
  endfunction

  // Squaring is linear: spread bits to even positions, then reduce
  function automatic logic [7:0] gf_sq(input logic [7:0] v);
    logic [14:0] t;
    t = '0;
    for (int i = 0; i < 8; i++) begin
      t[2*i] = v[i];
    end
    for (int i = 14; i >= 8; i--) begin
      if (t[i]) begin
        t[i -: 9] = t[i -: 9] ^ GF_POLY;
      end
    end
    return t[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gf256_arithmetic_unit.sv =====
// GF(2^8) unit over x^8+x^4+x^3+x+1: add, multiply, inverse, xtime.
// A result becomes valid after the transaction passes the front register, queue,
// two product stages and the output register, later while the output stalls.
// Throughput: one transaction per cycle while rsp_stall is low; the three-level
// product tree for the inverse is pipelined, so every operation flows at full rate.
// Reset (rst, synchronous): drops all transactions in flight, no results pend.
`timescale 1ns / 1ps
`default_nettype none

module gf256_arithmetic_unit #(
  parameter int unsigned QUEUE_DEPTH = gfa_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] operand_a,
  input  wire logic [7:0] operand_b,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic [7:0]      result
);
  import gfa_pkg::*;

  // Front register, queue entries, two stages and the output register
  localparam int unsigned CAPACITY = QUEUE_DEPTH + 4;
  localparam int unsigned FLIGHT_W = $clog2(CAPACITY + 1);

  logic  fe_valid;
  logic  fe_ready;
  item_t fe_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  gfa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .mode       (mode),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_item  (fe_item)
  );

  gfa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_item  (fe_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  gfa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .result     (result)
  );

  // Track transactions accepted but not yet delivered
  logic [FLIGHT_W-1:0] in_flight;
  logic                req_fire;
  logic                rsp_fire;

  assign req_fire = req_valid && !req_stall;
  assign rsp_fire = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (req_fire && !rsp_fire) begin
      in_flight <= in_flight + 1'b1;
    end else if (rsp_fire && !req_fire) begin
      in_flight <= in_flight - 1'b1;
    end
  end

  a_flight_bounded: assert property (@(posedge clk) disable iff (rst)
    in_flight <= FLIGHT_W'(CAPACITY))
    else $error("more transactions in flight than storage holds");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (rst)
    (in_flight == '0) |-> !rsp_valid)
    else $error("result presented with no transaction in flight");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!rsp_valid && !req_stall))
    else $error("pipeline not empty after reset");

  a_front_free_no_stall: assert property (@(posedge clk) disable iff (rst)
    !fe_valid |-> !req_stall)
    else $error("input stalled while front register is empty");

endmodule

`default_nettype wire

// ===== rtl/gfa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfa_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire logic [1:0]     mode,
  input  wire logic [7:0]     operand_a,
  input  wire logic [7:0]     operand_b,
  output logic                push_valid,
  input  wire logic           push_ready,
  output gfa_pkg::item_t      push_item
);
  import gfa_pkg::*;

  logic  fe_valid;
  item_t fe_item;
  op_t   op_dec;

  // Classify the mode code into an operation
  always_comb begin
    unique case (mode)
      OP_ADD:  op_dec = OP_ADD;
      OP_MUL:  op_dec = OP_MUL;
      OP_INV:  op_dec = OP_INV;
      default: op_dec = OP_XTIME;
    endcase
  end

  // Hold the transaction only while the queue refuses it
  assign req_stall  = fe_valid && !push_ready;
  assign push_valid = fe_valid;
  assign push_item  = fe_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_valid <= 1'b0;
    end else if (!req_stall) begin
      fe_valid <= req_valid;
    end
  end

  // Capture payload on acceptance
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      fe_item.op <= op_dec;
      fe_item.a  <= operand_a;
      fe_item.b  <= operand_b;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gfa_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfa_queue #(
  parameter int unsigned DEPTH = gfa_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire gfa_pkg::item_t push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output gfa_pkg::item_t      pop_item
);
  import gfa_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  // Write the incoming transaction at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gfa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfa_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire gfa_pkg::item_t item,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output logic [7:0]          result
);
  import gfa_pkg::*;

  // Stage 1: first product level
  logic       s1_valid;
  logic       s1_inv;
  logic [7:0] s1_m1;
  logic [7:0] s1_m2;
  logic [7:0] s1_m3;
  logic [7:0] s1_p128;
  // Stage 2: second product level
  logic       s2_valid;
  logic [7:0] s2_x;
  logic [7:0] s2_y;

  logic       out_ready;
  logic       s2_ready;
  logic       s1_ready;

  logic [7:0] p2, p4, p8, p16, p32, p64, p128;
  logic [7:0] m1_next;

  assign out_ready  = !rsp_valid || !rsp_stall;
  assign s2_ready   = !s2_valid || out_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign item_ready = s1_ready;

  // Powers a^(2^k) by repeated squaring (linear XOR network)
  always_comb begin
    p2   = gf_sq(item.a);
    p4   = gf_sq(p2);
    p8   = gf_sq(p4);
    p16  = gf_sq(p8);
    p32  = gf_sq(p16);
    p64  = gf_sq(p32);
    p128 = gf_sq(p64);
  end

  // Pick the first-level result per operation
  always_comb begin
    unique case (item.op)
      OP_ADD:   m1_next = item.a ^ item.b;
      OP_MUL:   m1_next = gf_mul(item.a, item.b);
      OP_INV:   m1_next = gf_mul(p2, p4);
      OP_XTIME: m1_next = gf_xtime(item.a);
    endcase
  end

  // Advance valid bits through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= item_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        rsp_valid <= s2_valid;
      end
    end
  end

  // Stage payloads; a^254 = (p2*p4)*(p8*p16) * (p32*p64)*p128
  always_ff @(posedge clk) begin
    if (s1_ready && item_valid) begin
      s1_inv  <= (item.op == OP_INV);
      s1_m1   <= m1_next;
      s1_m2   <= gf_mul(p8, p16);
      s1_m3   <= gf_mul(p32, p64);
      s1_p128 <= p128;
    end
    if (s2_ready && s1_valid) begin
      s2_x <= s1_inv ? gf_mul(s1_m1, s1_m2) : s1_m1;
      s2_y <= s1_inv ? gf_mul(s1_m3, s1_p128) : GF_ONE;
    end
    if (out_ready && s2_valid) begin
      result <= gf_mul(s2_x, s2_y);
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import gfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_OPS  = 1850;
  localparam int unsigned INV_ROUNDS  = 7;
  localparam int unsigned TAIL_CYCLES = 16;

  // One queued operation, or a marker that holds the sender until all results are back
  typedef struct {
    bit         drain;
    op_t        op;
    logic [7:0] a;
    logic [7:0] b;
  } field_op_t;

  // One predicted result byte with the operation that caused it
  typedef struct {
    op_t        op;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] value;
  } field_result_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic [1:0] mode      = OP_ADD;
  logic [7:0] operand_a = 8'h00;
  logic [7:0] operand_b = 8'h00;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [7:0] result;

  field_op_t     op_backlog[$];
  field_result_t field_results[$];
  int unsigned   cycle_cnt = 0;
  int unsigned   err_cnt   = 0;
  int unsigned   send_idle = 0;
  int unsigned   recv_idle = 0;

  gf256_arithmetic_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .mode      (mode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .result    (result)
  );

  always #6 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Multiply by x, folding the carried-out bit back in
  function automatic logic [7:0] fld_double(input logic [7:0] v);
    logic [7:0] s;
    s = {v[6:0], 1'b0};
    if (v[7]) begin
      s = s ^ GF_REDUCE;
    end
    return s;
  endfunction

  // Shift-and-add product, top bit of a first
  function automatic logic [7:0] fld_product(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 7; k >= 0; k--) begin
      acc = fld_double(acc);
      if (a[k]) begin
        acc = acc ^ b;
      end
    end
    return acc;
  endfunction

  // a^254 by repeated squaring; zero stays zero
  function automatic logic [7:0] fld_reciprocal(input logic [7:0] a);
    logic [7:0] prod;
    logic [7:0] pw;
    prod = GF_ONE;
    pw   = a;
    for (int r = 0; r < INV_ROUNDS; r++) begin
      pw   = fld_product(pw, pw);
      prod = fld_product(prod, pw);
    end
    return prod;
  endfunction

  function automatic logic [7:0] field_answer(input op_t op, input logic [7:0] a,
                                              input logic [7:0] b);
    logic [7:0] r;
    case (op)
      OP_ADD:  r = a ^ b;
      OP_MUL:  r = fld_product(a, b);
      OP_INV:  r = fld_reciprocal(a);
      default: r = fld_double(a);
    endcase
    return r;
  endfunction

  // Mostly short gaps, a few long ones; no gaps at all during calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (((cycle_cnt / 700) % 4) == 3) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [4];
    corners = '{8'h00, 8'h01, 8'h80, 8'hff};
    if ($urandom_range(0, 9) == 0) begin
      return corners[$urandom_range(0, 3)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_op(input op_t op, input logic [7:0] a, input logic [7:0] b);
    field_op_t t;
    t.drain = 1'b0;
    t.op    = op;
    t.a     = a;
    t.b     = b;
    op_backlog.push_back(t);
  endtask

  task automatic queue_drain();
    field_op_t t;
    t.drain = 1'b1;
    t.op    = OP_ADD;
    t.a     = 8'h00;
    t.b     = 8'h00;
    op_backlog.push_back(t);
  endtask

  // Driver: present queued transactions, record a prediction on each acceptance
  always @(posedge clk) begin : drive_proc
    logic          give;
    field_op_t     nxt;
    field_result_t rec;
    if (rst) begin
      req_valid <= 1'b0;
      send_idle = 0;
    end else begin
      give = req_valid;
      if (req_valid && !req_stall) begin
        rec.op    = op_t'(mode);
        rec.a     = operand_a;
        rec.b     = operand_b;
        rec.value = field_answer(op_t'(mode), operand_a, operand_b);
        field_results.push_back(rec);
        give      = 1'b0;
        send_idle = pick_gap();
      end
      if (!give) begin
        if (send_idle > 0) begin
          send_idle--;
        end else if (op_backlog.size() > 0) begin
          if (op_backlog[0].drain) begin
            // hold until the unit has returned everything
            if (field_results.size() == 0) begin
              void'(op_backlog.pop_front());
            end
          end else begin
            nxt       = op_backlog.pop_front();
            give      = 1'b1;
            mode      <= nxt.op;
            operand_a <= nxt.a;
            operand_b <= nxt.b;
          end
        end
      end
      req_valid <= give;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_proc
    field_result_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      recv_idle = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (field_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, actual %02h", $time, result);
        end else begin
          want = field_results.pop_front();
          if (result !== want.value) begin
            err_cnt++;
            $display("%0t: %s a=%02h b=%02h: expected %02h, actual %02h",
                     $time, want.op.name(), want.a, want.b, want.value, result);
          end
        end
      end
      // advance the receiver's stall pattern
      if (recv_idle > 0) begin
        recv_idle--;
        rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        recv_idle = pick_gap();
        rsp_stall <= (recv_idle > 0);
        if (recv_idle > 0) begin
          recv_idle--;
        end
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    // directed: field extremes, each operation, inverse of zero, b ignored
    queue_op(OP_ADD,   8'h00, 8'h00);
    queue_op(OP_ADD,   8'hff, 8'hff);
    queue_op(OP_ADD,   8'h55, 8'haa);
    queue_op(OP_MUL,   8'h00, 8'hff);
    queue_op(OP_MUL,   8'h01, 8'hff);
    queue_op(OP_MUL,   8'hff, 8'hff);
    queue_op(OP_MUL,   8'h02, 8'h87);
    queue_op(OP_MUL,   8'h53, 8'hca);
    queue_op(OP_MUL,   8'h57, 8'h83);
    queue_op(OP_MUL,   8'h80, 8'h01);
    queue_op(OP_INV,   8'h00, 8'h00);
    queue_op(OP_INV,   8'h00, 8'hff);
    queue_op(OP_INV,   8'h01, 8'h5a);
    queue_op(OP_INV,   8'hff, 8'hff);
    queue_op(OP_INV,   8'h53, 8'h00);
    queue_op(OP_INV,   8'h02, 8'ha5);
    queue_op(OP_INV,   8'h80, 8'h3c);
    queue_op(OP_XTIME, 8'h00, 8'hff);
    queue_op(OP_XTIME, 8'h7f, 8'h00);
    queue_op(OP_XTIME, 8'h80, 8'hff);
    queue_op(OP_XTIME, 8'hff, 8'h00);
    queue_op(OP_XTIME, 8'h01, 8'h96);
    queue_drain();

    // random operations, with a full drain now and then
    for (int i = 0; i < RANDOM_OPS; i++) begin
      queue_op(op_t'($urandom_range(0, 3)), pick_byte(), pick_byte());
      if ((i % 600) == 599) begin
        queue_drain();
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (op_backlog.size() != 0 || req_valid || field_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0 && field_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
